### rtl/set_assoc_cache_tag_controller_assert.svh
// Assertion macros shared by the cache tag controller RTL.
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_ASSERT_SVH

// Checked on every rising clock edge while reset is released.
`define SACT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, during reset as well.
`define SACT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/sact_pkg.sv
// Package with sizes, command codes and the line record of the cache tag controller.
package sact_pkg;

  localparam int unsigned DEF_WAYS    = 4;
  localparam int unsigned SETS        = 32;
  localparam int unsigned LINE_WORDS  = 16;
  localparam int unsigned LINE_BYTES  = LINE_WORDS * 4;
  localparam int unsigned OFFSET_BITS = $clog2(LINE_BYTES);
  localparam int unsigned SET_BITS    = $clog2(SETS);
  localparam int unsigned ADDR_BITS   = 32;
  localparam int unsigned TAG_BITS    = ADDR_BITS - SET_BITS - OFFSET_BITS;
  localparam int unsigned AGE_BITS    = 32;
  localparam int unsigned CNT_BITS    = 32;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic                dirty;
    logic                referenced;
    logic [AGE_BITS-1:0] age;
  } line_t;

endpackage

### rtl/set_assoc_cache_tag_controller.sv
// Tag lookup, second-chance replacement and read statistics of a set-associative cache.
//
//   channel | direction | payload
//   in      | input     | command_i, address_i
//   out     | output    | hit_o, way_o, writeback_needed_o, victim_line_address_o,
//           |           | fill_needed_o, fill_line_address_o, read_hit_total_o,
//           |           | read_miss_total_o
//
// One access per cycle while the result is not stalled: the set row is read from the tag
// memory when the access is accepted, and lookup, victim choice and row update finish when
// the pending access advances, which registers the result. A back-to-back access to the same
// set takes the just written row from a forwarding register instead of the memory port.
// Reset clears the valid bits and the counters at once; no clearing pass is needed.
// A stalled result holds the pending access, which then holds the input.
module set_assoc_cache_tag_controller #(
  parameter int unsigned WAYS = sact_pkg::DEF_WAYS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [0:0]  command_i,
  input  logic [31:0] address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [1:0]  way_o,
  output logic        writeback_needed_o,
  output logic [31:0] victim_line_address_o,
  output logic        fill_needed_o,
  output logic [31:0] fill_line_address_o,
  output logic [31:0] read_hit_total_o,
  output logic [31:0] read_miss_total_o
);

  `include "set_assoc_cache_tag_controller_assert.svh"

  localparam int unsigned WW  = $clog2(WAYS);
  localparam int unsigned WOW = (WW > 2) ? WW : 2;
  localparam int unsigned SB  = sact_pkg::SET_BITS;
  localparam int unsigned OB  = sact_pkg::OFFSET_BITS;
  localparam int unsigned TB  = sact_pkg::TAG_BITS;
  localparam int unsigned CB  = sact_pkg::CNT_BITS;

  typedef sact_pkg::line_t [WAYS-1:0] row_t;

  // Tag memory, one row per set holding all ways.
  row_t tag_mem [sact_pkg::SETS];

  logic [WAYS-1:0] valid_q [sact_pkg::SETS];

  // Pending access.
  logic        s1_valid_q;
  logic        s1_cmd_q;
  logic [31:0] s1_addr_q;
  row_t        rd_row_q;

  // Last written row, forwarded to an access that read the memory in the same cycle.
  logic          byp_valid_q;
  logic [SB-1:0] byp_set_q;
  row_t          byp_row_q;

  logic [CB-1:0] read_hits_q, read_hits_d;
  logic [CB-1:0] read_misses_q, read_misses_d;
  logic [CB-1:0] total_q, total_d;

  logic        out_valid_q;
  logic        out_hit_q;
  logic [1:0]  out_way_q;
  logic        out_wb_q;
  logic [31:0] out_victim_q;
  logic        out_fill_q;
  logic [31:0] out_fill_addr_q;

  logic          advance;
  logic          in_fire;
  logic [SB-1:0] in_set;
  logic [SB-1:0] set;
  logic [TB-1:0] tag;
  logic          is_write;
  row_t          row;
  row_t          row_n;
  logic [WAYS-1:0] vld;
  logic [WAYS-1:0] vld_n;
  logic          hit;
  logic [WW-1:0] hit_way;
  logic          free_found;
  logic [WW-1:0] free_way;
  logic [WW-1:0] oldest;
  logic [WW-1:0] victim;
  logic          ref_found;
  logic [WW:0]   idx_sum;
  logic [WW-1:0] idx;
  logic [WW-1:0] way_sel;
  logic [WOW-1:0] way_wide;
  logic          wb;
  logic [31:0]   victim_addr;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_set     = address_i[OB +: SB];

  assign set      = s1_addr_q[OB +: SB];
  assign tag      = s1_addr_q[OB+SB +: TB];
  assign is_write = (s1_cmd_q == sact_pkg::CMD_WRITE);
  assign row      = (byp_valid_q && (byp_set_q == set)) ? byp_row_q : rd_row_q;
  assign vld      = valid_q[set];

  always_comb begin
    hit        = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && vld[w] && (row[w].tag == tag)) begin
        hit     = 1'b1;
        hit_way = WW'(w);
      end
      if (!free_found && !vld[w]) begin
        free_found = 1'b1;
        free_way   = WW'(w);
      end
    end
  end

  // Oldest way, lowest index on equal ages.
  always_comb begin
    oldest = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (row[w].age < row[oldest].age) begin
        oldest = WW'(w);
      end
    end
  end

  always_comb begin
    read_hits_d   = read_hits_q;
    read_misses_d = read_misses_q;
    if (!is_write) begin
      if (hit) begin
        read_hits_d = read_hits_q + 1'b1;
      end else begin
        read_misses_d = read_misses_q + 1'b1;
      end
    end
    total_d = total_q + CB'(!is_write);
  end

  // Second-chance sweep from the oldest way on a miss with no free way, then the row update.
  always_comb begin
    row_n     = row;
    vld_n     = vld;
    victim    = oldest;
    ref_found = 1'b0;
    idx_sum   = '0;
    idx       = '0;
    if (!hit && !free_found) begin
      for (int n = 0; n < WAYS; n++) begin
        idx_sum = {1'b0, oldest} + (WW+1)'(n);
        if (idx_sum >= (WW+1)'(WAYS)) begin
          idx_sum = idx_sum - (WW+1)'(WAYS);
        end
        idx = idx_sum[WW-1:0];
        if (!ref_found) begin
          if (!row[idx].referenced) begin
            ref_found = 1'b1;
            victim    = idx;
          end else begin
            row_n[idx].referenced = 1'b0;
          end
        end
      end
    end

    if (hit) begin
      way_sel = hit_way;
    end else if (free_found) begin
      way_sel = free_way;
    end else begin
      way_sel = victim;
    end

    wb          = !hit && vld[way_sel] && row[way_sel].dirty;
    victim_addr = wb ? {row[way_sel].tag, set, OB'(0)} : 32'd0;

    if (hit) begin
      if (is_write) begin
        row_n[way_sel].dirty = 1'b1;
      end else begin
        row_n[way_sel].referenced = 1'b1;
        row_n[way_sel].age        = total_d;
      end
    end else begin
      row_n[way_sel].tag        = tag;
      row_n[way_sel].dirty      = is_write;
      row_n[way_sel].referenced = 1'b0;
      row_n[way_sel].age        = total_d;
      vld_n[way_sel]            = 1'b1;
    end
  end

  assign way_wide = WOW'(way_sel);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      tag_mem[set] <= row_n;
    end
    if (in_fire) begin
      rd_row_q <= tag_mem[in_set];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < sact_pkg::SETS; s++) begin
        valid_q[s] <= '0;
      end
      s1_valid_q    <= 1'b0;
      byp_valid_q   <= 1'b0;
      out_valid_q   <= 1'b0;
      read_hits_q   <= '0;
      read_misses_q <= '0;
      total_q       <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        valid_q[set]  <= vld_n;
        byp_valid_q   <= 1'b1;
        out_valid_q   <= 1'b1;
        read_hits_q   <= read_hits_d;
        read_misses_q <= read_misses_d;
        total_q       <= total_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q  <= command_i[0];
      s1_addr_q <= address_i;
    end
    if (advance) begin
      byp_set_q       <= set;
      byp_row_q       <= row_n;
      out_hit_q       <= hit;
      out_way_q       <= way_wide[1:0];
      out_wb_q        <= wb;
      out_victim_q    <= victim_addr;
      out_fill_q      <= !hit;
      out_fill_addr_q <= hit ? 32'd0 : {s1_addr_q[31:OB], OB'(0)};
    end
  end

  assign out_valid_o           = out_valid_q;
  assign hit_o                 = out_hit_q;
  assign way_o                 = out_way_q;
  assign writeback_needed_o    = out_wb_q;
  assign victim_line_address_o = out_victim_q;
  assign fill_needed_o         = out_fill_q;
  assign fill_line_address_o   = out_fill_addr_q;
  assign read_hit_total_o      = read_hits_q;
  assign read_miss_total_o     = read_misses_q;

  `SACT_ASSERT_ALWAYS(a_total_tracks_counters, !rst_ni || (total_q == read_hits_q + read_misses_q), "running total out of step with the read counters")
  `SACT_ASSERT(a_advance_gives_result, advance |=> out_valid_q, "processed access produced no result")
  `SACT_ASSERT(a_wb_only_on_fill, out_valid_q && out_wb_q |-> out_fill_q && !out_hit_q, "write back reported without a line fill")
  `SACT_ASSERT(a_hits_stable_without_read_hit, !(advance && hit && !is_write) |=> $stable(read_hits_q), "read hit counter moved without a read hit")

endmodule
